// ----- hdl/mtat_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-turn angle tracker package
// Shared widths, scale constants and codes for the tracker and its divider.
// ----------------------------------------------------------------------------
package mtat_pkg;

    localparam int ANGLE_W   = 12;
    localparam int TIME_W    = 32;
    localparam int TURN_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int VEL_W     = 22;
    localparam int RPM_W     = 23;

    // |step| * 1000 fits 21 bits, |step| * 46875 fits 27 bits (|step| <= 2048)
    localparam int VEL_NUM_W = 21;
    localparam int RPM_NUM_W = 27;
    localparam int DIV_NUM_W = 27;
    localparam int DIV_CNT_W = 5;

    // 6000000 / 4096 = 46875 / 32: divide by elapsed, then drop five bits
    localparam logic [9:0]  VEL_SCALE = 10'd1000;
    localparam logic [15:0] RPM_SCALE = 16'd46875;
    localparam int          RPM_SHIFT = 5;

    localparam logic signed [ANGLE_W:0]   HALF_TURN = 13'sd2048;
    localparam logic signed [ANGLE_W+1:0] FULL_TURN = 14'sd4096;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_UPDATED  = 3'd0;
    localparam t_status ST_FIRST    = 3'd1;
    localparam t_status ST_SAME_MS  = 3'd2;
    localparam t_status ST_READ_ERR = 3'd3;
    localparam t_status ST_DISABLED = 3'd4;

    localparam logic CFG_ZERO_POS = 1'b0;
    localparam logic CFG_ENABLE   = 1'b1;

endpackage

// ----- hdl/mtat_div.sv -----
// ----------------------------------------------------------------------------
// Multi-turn angle tracker divider
// Restoring divider, one quotient bit per cycle over a programmable bit count.
// ----------------------------------------------------------------------------
module mtat_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mtat_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [mtat_pkg::DIV_CNT_W-1:0] i_steps,
    input  logic [mtat_pkg::TIME_W-1:0]    i_den,
    output logic                           o_done,
    output logic [mtat_pkg::DIV_NUM_W-1:0] o_quot
);

    localparam logic [mtat_pkg::DIV_CNT_W-1:0] DIV_CNT_ONE = 1;

    logic [mtat_pkg::TIME_W-1:0]    r_rem;
    logic [mtat_pkg::TIME_W-1:0]    r_den;
    logic [mtat_pkg::DIV_NUM_W-1:0] r_num;
    logic [mtat_pkg::DIV_NUM_W-1:0] r_quot;
    logic [mtat_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;

    logic [mtat_pkg::TIME_W:0]      shifted;
    logic [mtat_pkg::TIME_W:0]      diff;
    logic                           fits;

    always_comb begin
        shifted = {r_rem, r_num[mtat_pkg::DIV_NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_steps;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_ONE) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_num  <= i_num;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? diff[mtat_pkg::TIME_W-1:0] : shifted[mtat_pkg::TIME_W-1:0];
            r_num  <= {r_num[mtat_pkg::DIV_NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[mtat_pkg::DIV_NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hdl/multi_turn_angle_tracker.sv -----
// ----------------------------------------------------------------------------
// Multi-turn angle tracker
// Per-channel angle unwrap with turn count, velocity and rpm over one shared
// iterative divider.
// ----------------------------------------------------------------------------
// Sequence: an updating sample passes evaluate, multiply, then the velocity and
//   rpm divisions on the shared divider (21 quotient bits for velocity, 27 for rpm).
// Any other outcome (first, same-ms, read error, disabled) goes straight to output.
// Throughput: one sample at a time; the next is taken the cycle after the
//   result is loaded into the output register, which a stalled output holds off.
// Reset: synchronous active low; clears config, channel state and handshakes.
module multi_turn_angle_tracker #(
    parameter int CHANNELS = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_channel,
    input  logic [mtat_pkg::ANGLE_W-1:0]          i_raw_angle,
    input  logic                                  i_read_ok,
    input  logic [mtat_pkg::TIME_W-1:0]           i_time_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [mtat_pkg::STATUS_W-1:0]         o_status,
    output logic signed [mtat_pkg::TURN_W-1:0]    o_turn_count,
    output logic signed [mtat_pkg::VEL_W-1:0]     o_velocity_counts,
    output logic signed [mtat_pkg::RPM_W-1:0]     o_rpm_hundredths,
    output logic [mtat_pkg::ANGLE_W-1:0]          o_angle_from_zero,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [mtat_pkg::ANGLE_W-1:0]          i_cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EVAL    = 3'd1;
    localparam logic [2:0] S_MUL     = 3'd2;
    localparam logic [2:0] S_DV_GO   = 3'd3;
    localparam logic [2:0] S_DV_WAIT = 3'd4;
    localparam logic [2:0] S_DR_GO   = 3'd5;
    localparam logic [2:0] S_DR_WAIT = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    localparam int VEL_Q_W = mtat_pkg::VEL_NUM_W;
    localparam int RPM_Q_W = mtat_pkg::RPM_NUM_W - mtat_pkg::RPM_SHIFT;

    logic [2:0] r_state;

    // configuration
    logic [mtat_pkg::ANGLE_W-1:0] r_zero;
    logic [2:0]                   r_enable;

    // per-channel state
    logic [mtat_pkg::TIME_W-1:0]  r_last_time  [CHANNELS];
    logic [mtat_pkg::ANGLE_W-1:0] r_last_angle [CHANNELS];
    logic [mtat_pkg::TURN_W-1:0]  r_turns      [CHANNELS];

    // latched sample
    logic [1:0]                   r_ch;
    logic [mtat_pkg::ANGLE_W-1:0] r_raw;
    logic                         r_ok;
    logic [mtat_pkg::TIME_W-1:0]  r_time;

    // working values
    logic [mtat_pkg::TIME_W-1:0]    r_elapsed;
    logic [mtat_pkg::ANGLE_W-1:0]   r_mag;
    logic                           r_neg;
    logic [mtat_pkg::VEL_NUM_W-1:0] r_num_v;
    logic [mtat_pkg::RPM_NUM_W-1:0] r_num_r;

    // pending result
    mtat_pkg::t_status                       r_res_status;
    logic [mtat_pkg::TURN_W-1:0]             r_res_turns;
    logic [mtat_pkg::VEL_W-1:0]              r_res_vel;
    logic [mtat_pkg::RPM_W-1:0]              r_res_rpm;
    logic [mtat_pkg::ANGLE_W-1:0]            r_res_rel;

    // output register
    logic                                    r_out_valid;
    mtat_pkg::t_status                       r_out_status;
    logic [mtat_pkg::TURN_W-1:0]             r_out_turns;
    logic [mtat_pkg::VEL_W-1:0]              r_out_vel;
    logic [mtat_pkg::RPM_W-1:0]              r_out_rpm;
    logic [mtat_pkg::ANGLE_W-1:0]            r_out_rel;

    // evaluation
    logic [3:0]                     en_ext;
    logic                           ch_ok;
    logic [CH_W-1:0]                idx;
    logic [mtat_pkg::TIME_W-1:0]    cur_time;
    logic [mtat_pkg::ANGLE_W-1:0]   cur_angle;
    logic [mtat_pkg::TURN_W-1:0]    cur_turns;
    logic signed [mtat_pkg::ANGLE_W:0] raw_step;
    logic signed [mtat_pkg::ANGLE_W:0] step;
    logic [mtat_pkg::TURN_W-1:0]    n_turns;
    logic [mtat_pkg::ANGLE_W:0]     step_abs;
    logic [mtat_pkg::ANGLE_W-1:0]   rel_angle;

    // divider
    logic                           div_start;
    logic [mtat_pkg::DIV_NUM_W-1:0] div_num;
    logic [mtat_pkg::DIV_CNT_W-1:0] div_steps;
    logic                           div_done;
    logic [mtat_pkg::DIV_NUM_W-1:0] div_quot;
    logic [VEL_Q_W:0]               vel_mag;
    logic [RPM_Q_W:0]               rpm_mag;

    logic                           out_load;

    always_comb begin
        en_ext    = {1'b0, r_enable};
        ch_ok     = (32'(r_ch) < CHANNELS) && en_ext[r_ch];
        idx       = r_ch[CH_W-1:0];
        cur_time  = r_last_time[idx];
        cur_angle = r_last_angle[idx];
        cur_turns = r_turns[idx];
        rel_angle = r_raw - r_zero;
        raw_step  = $signed({1'b0, r_raw}) - $signed({1'b0, cur_angle});
        // fold steps beyond half a turn; exactly half a turn is no wrap
        if (raw_step > mtat_pkg::HALF_TURN) begin
            step    = 13'(raw_step - mtat_pkg::FULL_TURN);
            n_turns = cur_turns - 1'b1;
        end else if (raw_step < -mtat_pkg::HALF_TURN) begin
            step    = 13'(raw_step + mtat_pkg::FULL_TURN);
            n_turns = cur_turns + 1'b1;
        end else begin
            step    = raw_step;
            n_turns = cur_turns;
        end
        step_abs = step[mtat_pkg::ANGLE_W] ? 13'(-step) : 13'(step);
    end

    always_comb begin
        div_start = (r_state == S_DV_GO) || (r_state == S_DR_GO);
        if (r_state == S_DV_GO) begin
            div_num   = {r_num_v, (mtat_pkg::DIV_NUM_W - mtat_pkg::VEL_NUM_W)'(0)};
            div_steps = mtat_pkg::DIV_CNT_W'(mtat_pkg::VEL_NUM_W);
        end else begin
            div_num   = mtat_pkg::DIV_NUM_W'(r_num_r);
            div_steps = mtat_pkg::DIV_CNT_W'(mtat_pkg::RPM_NUM_W);
        end
        vel_mag  = {1'b0, div_quot[VEL_Q_W-1:0]};
        rpm_mag  = {1'b0, div_quot[mtat_pkg::DIV_NUM_W-1:mtat_pkg::RPM_SHIFT]};
        out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    end

    mtat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_steps (div_steps),
        .i_den   (r_elapsed),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero   <= '0;
            r_enable <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mtat_pkg::CFG_ZERO_POS: r_zero   <= i_cfg_data;
                mtat_pkg::CFG_ENABLE:   r_enable <= i_cfg_data[2:0];
                default:                r_zero   <= r_zero;
            endcase
        end
    end

    // sequencer and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int c = 0; c < CHANNELS; c++) begin
                r_last_time[c]  <= '0;
                r_last_angle[c] <= '0;
                r_turns[c]      <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (ch_ok && r_ok && cur_time == '0) begin
                        r_last_time[idx]  <= r_time;
                        r_last_angle[idx] <= r_raw;
                        r_state           <= S_OUT;
                    end else if (ch_ok && r_ok && r_time != cur_time) begin
                        r_last_time[idx]  <= r_time;
                        r_last_angle[idx] <= r_raw;
                        r_turns[idx]      <= n_turns;
                        r_state           <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MUL:     r_state <= S_DV_GO;
                S_DV_GO:   r_state <= S_DV_WAIT;
                S_DV_WAIT: begin
                    if (div_done) begin
                        r_state <= S_DR_GO;
                    end
                end
                S_DR_GO:   r_state <= S_DR_WAIT;
                S_DR_WAIT: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_ch   <= i_channel;
            r_raw  <= i_raw_angle;
            r_ok   <= i_read_ok;
            r_time <= i_time_ms;
        end
        if (r_state == S_EVAL) begin
            r_elapsed    <= r_time - cur_time;
            r_mag        <= step_abs[mtat_pkg::ANGLE_W-1:0];
            r_neg        <= step[mtat_pkg::ANGLE_W];
            r_res_vel    <= '0;
            r_res_rpm    <= '0;
            priority if (!ch_ok) begin
                r_res_status <= mtat_pkg::ST_DISABLED;
                r_res_turns  <= '0;
                r_res_rel    <= '0;
            end else if (!r_ok) begin
                r_res_status <= mtat_pkg::ST_READ_ERR;
                r_res_turns  <= cur_turns;
                r_res_rel    <= '0;
            end else if (cur_time == '0) begin
                r_res_status <= mtat_pkg::ST_FIRST;
                r_res_turns  <= cur_turns;
                r_res_rel    <= rel_angle;
            end else if (r_time == cur_time) begin
                r_res_status <= mtat_pkg::ST_SAME_MS;
                r_res_turns  <= cur_turns;
                r_res_rel    <= '0;
            end else begin
                r_res_status <= mtat_pkg::ST_UPDATED;
                r_res_turns  <= n_turns;
                r_res_rel    <= rel_angle;
            end
        end
        if (r_state == S_MUL) begin
            r_num_v <= mtat_pkg::VEL_NUM_W'(r_mag)
                     * mtat_pkg::VEL_NUM_W'(mtat_pkg::VEL_SCALE);
            r_num_r <= mtat_pkg::RPM_NUM_W'(r_mag)
                     * mtat_pkg::RPM_NUM_W'(mtat_pkg::RPM_SCALE);
        end
        if (r_state == S_DV_WAIT && div_done) begin
            r_res_vel <= r_neg ? mtat_pkg::VEL_W'(-vel_mag) : mtat_pkg::VEL_W'(vel_mag);
        end
        if (r_state == S_DR_WAIT && div_done) begin
            r_res_rpm <= r_neg ? mtat_pkg::RPM_W'(-rpm_mag) : mtat_pkg::RPM_W'(rpm_mag);
        end
    end

    // output register: hold while stalled, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_turns  <= r_res_turns;
            r_out_vel    <= r_res_vel;
            r_out_rpm    <= r_res_rpm;
            r_out_rel    <= r_res_rel;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_turn_count      = $signed(r_out_turns);
    assign o_velocity_counts = $signed(r_out_vel);
    assign o_rpm_hundredths  = $signed(r_out_rpm);
    assign o_angle_from_zero = r_out_rel;

endmodule
